### src/wsm_pkg.sv
// Shared constants for the wildcard substring matcher.
package wsm_pkg;

	localparam logic [7:0] ASTERISK  = 8'h2A;
	localparam logic [7:0] BACKSLASH = 8'h5C;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

endpackage

### src/wildcard_substring_matcher.sv
// Top level: pattern loader, NFA state and the request/result pipeline.
//
// Channel | Direction | Signals
// in      | in        | in_valid, in_stall, command, data_byte, last
// out     | out       | out_valid, out_stall, found, text_end, pattern_overflow
//
// One request per clock while in_stall is low; each gives one result through the input reg, then the result reg.
// A request is taken while a result waits, until the result register is stalled and the input reg is full.
// Pattern elements live in per-slot registers; the whole NFA step is combinational.
// Reset: empty pattern, position zero active, no found, no overflow.
// in_stall rises only when both the input and result registers are held.
module wildcard_substring_matcher #(
	parameter int MAX_PATTERN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic       text_end,
	output logic       pattern_overflow
);
	import wsm_pkg::*;

	localparam int N     = MAX_PATTERN;
	localparam int LEN_W = $clog2(N + 1);
	localparam int SUM_W = LEN_W + 1;

	// input stage
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result stage
	logic found_s2;
	logic end_s2;
	logic ovf_s2;

	// matcher state
	logic [LEN_W-1:0] len_q;
	logic             pend_q;
	logic             ovf_q;
	logic             loading_q;
	logic             found_q;
	logic [N:0]       act_q;
	logic [N:0]       init_q;
	logic [7:0]       elem_byte_q [N];
	logic [N-1:0]     elem_wild_q;

	logic s2_free;
	logic move_s1;
	logic is_text;

	// pattern side
	logic             new_pat;
	logic [LEN_W-1:0] start_len;
	logic             base_pend;
	logic             base_ovf;
	logic [N:0]       base_init;
	logic             is_bs;
	logic             is_ast;
	logic [7:0]       slot0_byte;
	logic             slot0_wild;
	logic [1:0]       pat_add;
	logic [SUM_W-1:0] pat_sum;
	logic [SUM_W-1:0] slot1_idx;
	logic [LEN_W-1:0] pat_len_new;
	logic             pat_ovf_new;
	logic             pat_pend_new;
	logic [N:0]       init_new;

	// text side
	logic             fin;
	logic [SUM_W-1:0] txt_sum;
	logic [LEN_W-1:0] eff_len;
	logic             eff_ovf;
	logic [N:0]       next_act;
	logic             hit;
	logic             txt_found;

	assign s2_free  = !out_valid || !out_stall;
	assign move_s1  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign is_text  = (cmd_s1 == CMD_TEXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= command;
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// pattern decode: up to two elements per byte; a pending backslash is
	// pre-written as a literal in the next slot so a closing text byte can use it
	assign new_pat   = !loading_q;
	assign start_len = new_pat ? '0 : len_q;
	assign base_pend = new_pat ? 1'b0 : pend_q;
	assign base_ovf  = new_pat ? 1'b0 : ovf_q;
	assign base_init = new_pat ? (N+1)'(1) : init_q;

	assign is_bs  = (byte_s1 == BACKSLASH);
	assign is_ast = (byte_s1 == ASTERISK);

	assign slot0_byte = base_pend ? (is_ast ? ASTERISK : BACKSLASH) : byte_s1;
	assign slot0_wild = !base_pend && is_ast;

	always_comb begin
		if (base_pend) begin
			if (is_ast)
				pat_add = 2'd1;
			else if (is_bs && !last_s1)
				pat_add = 2'd1;
			else
				pat_add = 2'd2;
		end else begin
			pat_add = (is_bs && !last_s1) ? 2'd0 : 2'd1;
		end
	end

	assign pat_sum      = SUM_W'(start_len) + SUM_W'(pat_add);
	assign slot1_idx    = SUM_W'(start_len) + SUM_W'(1);
	assign pat_len_new  = (pat_sum > SUM_W'(N)) ? LEN_W'(N) : pat_sum[LEN_W-1:0];
	assign pat_ovf_new  = base_ovf | (pat_sum > SUM_W'(N));
	assign pat_pend_new = is_bs && !last_s1;

	always_comb begin
		init_new = base_init;
		for (int i = 0; i < N; i++) begin
			if (slot0_wild && start_len == LEN_W'(i) && base_init[i])
				init_new[i+1] = 1'b1;
		end
	end

	// text scan: an unclosed pattern with a trailing backslash is closed here
	assign fin       = loading_q && pend_q;
	assign txt_sum   = SUM_W'(len_q) + SUM_W'(fin);
	assign eff_len   = (txt_sum > SUM_W'(N)) ? LEN_W'(N) : txt_sum[LEN_W-1:0];
	assign eff_ovf   = ovf_q | (txt_sum > SUM_W'(N));
	assign txt_found = found_q | (hit && !eff_ovf);

	wsm_nfa #(
		.N     (N),
		.LEN_W (LEN_W)
	) u_nfa (
		.act       (act_q),
		.wild      (elem_wild_q),
		.elem_byte (elem_byte_q),
		.eff_len   (eff_len),
		.data_byte (byte_s1),
		.next_act  (next_act),
		.hit       (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			pend_q    <= 1'b0;
			ovf_q     <= 1'b0;
			loading_q <= 1'b0;
			found_q   <= 1'b0;
			act_q     <= (N+1)'(1);
			init_q    <= (N+1)'(1);
		end else if (move_s1) begin
			if (is_text) begin
				loading_q <= 1'b0;
				pend_q    <= 1'b0;
				len_q     <= eff_len;
				ovf_q     <= eff_ovf;
				found_q   <= last_s1 ? 1'b0 : txt_found;
				act_q     <= last_s1 ? init_q : next_act;
			end else begin
				loading_q <= !last_s1;
				pend_q    <= pat_pend_new;
				len_q     <= pat_len_new;
				ovf_q     <= pat_ovf_new;
				found_q   <= 1'b0;
				act_q     <= init_new;
				init_q    <= init_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && !is_text) begin
			for (int i = 0; i < N; i++) begin
				if (start_len == LEN_W'(i)) begin
					elem_byte_q[i] <= slot0_byte;
					elem_wild_q[i] <= slot0_wild;
				end else if (slot1_idx == SUM_W'(i)) begin
					elem_byte_q[i] <= byte_s1;
					elem_wild_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (s2_free)
			out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			found_s2 <= is_text ? txt_found : 1'b0;
			end_s2   <= is_text ? last_s1 : 1'b0;
			ovf_s2   <= is_text ? eff_ovf : pat_ovf_new;
		end
	end

	assign found            = found_s2;
	assign text_end         = end_s2;
	assign pattern_overflow = ovf_s2;

	// an overflowed pattern never reports a match
	a_no_found_on_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pattern_overflow |-> !found)
		else $error("found reported with pattern overflow");

	// a match may start at any byte, so position zero stays live
	a_pos0_active: assert property (@(posedge clk) disable iff (!arst_n)
		act_q[0] && init_q[0])
		else $error("position zero dropped from active set");

	a_pend_loading: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> loading_q)
		else $error("pending backslash outside pattern load");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(len_q) <= SUM_W'(N))
		else $error("pattern length beyond capacity");

endmodule

### src/wsm_nfa.sv
// Bit-parallel NFA step: per-element match lanes plus wildcard closure.
module wsm_nfa #(
	parameter int N     = 32,
	parameter int LEN_W = 6
) (
	input  logic [N:0]       act,
	input  logic [N-1:0]     wild,
	input  logic [7:0]       elem_byte [N],
	input  logic [LEN_W-1:0] eff_len,
	input  logic [7:0]       data_byte,
	output logic [N:0]       next_act,
	output logic             hit
);
	import wsm_pkg::*;

	localparam int LEVELS = $clog2(N + 1);

	always_comb begin
		logic [N:0]   g;
		logic [N:0]   p;
		logic [N-1:0] lane_en;
		int           d;
		g = '0;
		p = '0;
		g[0] = 1'b1;
		for (int i = 0; i < N; i++) begin
			lane_en[i] = LEN_W'(i) < eff_len;
			p[i+1] = lane_en[i] & wild[i];
			if (lane_en[i] && act[i]) begin
				if (wild[i])
					g[i] = 1'b1;
				else if (elem_byte[i] == data_byte)
					g[i+1] = 1'b1;
			end
		end
		// closure over runs of wildcards, log-depth prefix
		for (int lv = 0; lv < LEVELS; lv++) begin
			d = 1 << lv;
			for (int j = N; j >= 1; j--) begin
				if (j >= d) begin
					g[j] = g[j] | (p[j] & g[j-d]);
					p[j] = p[j] & p[j-d];
				end
			end
		end
		next_act = g;
		hit = act[eff_len] | g[eff_len];
	end

endmodule
